@@ design/hlfr_pkg.sv @@
package hlfr_pkg;

  // Frame store depth in bytes (header, length and payload)
  localparam int FBD = 32;
  // Index into the frame store, and a position that can also hold the depth
  localparam int IDX_W = $clog2(FBD);
  localparam int POS_W = $clog2(FBD + 1);

  // Header bytes
  localparam logic [7:0] HEAD_FIRST  = 8'h23;
  localparam logic [7:0] HEAD_SECOND = 8'h40;
  localparam logic [7:0] LEN_ZERO    = 8'h00;
  // Largest payload length that still fits behind the three header bytes
  localparam logic [7:0] LEN_MAX     = 8'(FBD - 3);

  // Commands from controller to datapath
  typedef struct packed {
    logic write;        // store rx_byte at write position, advance
    logic write_first;  // store rx_byte at entry 0, position becomes 1
    logic pos_one;      // position back to 1, keep stored '#'
    logic load_len;     // payload counter takes rx_byte
    logic dec;          // one payload byte taken
    logic start_drain;  // latch frame length, rewind read pointer
    logic drain;        // read frame out
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_first;
    logic is_second;
    logic len_bad;
    logic last_payload;
    logic drain_end;
  } status_t;

endpackage

@@ design/hlfr_in_if.sv @@
interface hlfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

@@ design/hlfr_out_if.sv @@
interface hlfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;

  modport source (output valid, output frame_byte, output frame_last, input ready);
  modport sink (input valid, input frame_byte, input frame_last, output ready);
endinterface

@@ design/hlfr_ctrl.sv @@
module hlfr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             rx_valid,
  output logic             rx_ready,
  input  hlfr_pkg::status_t st,
  output hlfr_pkg::cmd_t    cmd
);
  import hlfr_pkg::*;

  typedef enum logic [2:0] {
    HUNT_FIRST,
    HUNT_SECOND,
    GET_LEN,
    PAYLOAD,
    DRAIN
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign rx_ready = (state != DRAIN);
  assign accept   = rx_valid && rx_ready;

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      HUNT_FIRST: begin
        if (accept && st.is_first) begin
          cmd.write_first = 1'b1;
          state_next      = HUNT_SECOND;
        end
      end
      HUNT_SECOND: begin
        if (accept) begin
          if (st.is_second) begin
            cmd.write  = 1'b1;
            state_next = GET_LEN;
          end else if (!st.is_first) begin
            state_next = HUNT_FIRST;
          end
        end
      end
      GET_LEN: begin
        if (accept) begin
          if (st.is_first) begin
            cmd.pos_one = 1'b1;
            state_next  = HUNT_SECOND;
          end else if (st.len_bad) begin
            state_next = HUNT_FIRST;
          end else begin
            cmd.write    = 1'b1;
            cmd.load_len = 1'b1;
            state_next   = PAYLOAD;
          end
        end
      end
      PAYLOAD: begin
        if (accept) begin
          cmd.write = 1'b1;
          cmd.dec   = 1'b1;
          if (st.last_payload) begin
            cmd.start_drain = 1'b1;
            state_next      = DRAIN;
          end
        end
      end
      DRAIN: begin
        cmd.drain = 1'b1;
        if (st.drain_end) begin
          state_next = HUNT_FIRST;
        end
      end
      default: begin
        state_next = HUNT_FIRST;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= HUNT_FIRST;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ design/hlfr_dp.sv @@
module hlfr_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        rx_byte,
  input  hlfr_pkg::cmd_t    cmd,
  output hlfr_pkg::status_t st,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_last
);
  import hlfr_pkg::*;

  logic [7:0]       mem [FBD];
  logic [POS_W-1:0] wr_pos;
  logic [7:0]       remaining;
  logic [POS_W-1:0] rd_ptr;
  logic [POS_W-1:0] drain_len;
  logic             load;
  logic             load_last;

  // Byte classification for the controller
  assign st.is_first     = (rx_byte == HEAD_FIRST);
  assign st.is_second    = (rx_byte == HEAD_SECOND);
  assign st.len_bad      = (rx_byte == LEN_ZERO) || (rx_byte > LEN_MAX);
  assign st.last_payload = (remaining == 8'd1);

  // Readout advances whenever the output register is free or being taken
  assign load         = cmd.drain && (!out_valid || out_ready);
  assign load_last    = (rd_ptr + 1'b1) == drain_len;
  assign st.drain_end = load && load_last;

  // Frame store write side
  always_ff @(posedge clk) begin
    if (cmd.write_first) begin
      mem[0] <= rx_byte;
    end else if (cmd.write) begin
      mem[wr_pos[IDX_W-1:0]] <= rx_byte;
    end
  end

  // Write position, payload counter, read pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos    <= '0;
      remaining <= '0;
    end else begin
      if (cmd.write_first || cmd.pos_one) begin
        wr_pos <= POS_W'(1);
      end else if (cmd.write) begin
        wr_pos <= wr_pos + 1'b1;
      end
      if (cmd.load_len) begin
        remaining <= rx_byte;
      end else if (cmd.dec) begin
        remaining <= remaining - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_drain) begin
      drain_len <= wr_pos + 1'b1;
      rd_ptr    <= '0;
    end else if (load) begin
      rd_ptr <= rd_ptr + 1'b1;
    end
  end

  // Registered read straight into the output register
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= mem[rd_ptr[IDX_W-1:0]];
      out_last <= load_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Writes never run past the store
  a_wr_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.write |-> (wr_pos < POS_W'(FBD)))
    else $error("frame store write beyond depth");

  // Reads stay inside the latched frame
  a_rd_in_range: assert property (@(posedge clk) disable iff (rst)
    load |-> (rd_ptr < drain_len))
    else $error("frame readout beyond frame length");

  // End of drain puts a marked last byte on the output
  a_last_shown: assert property (@(posedge clk) disable iff (rst)
    st.drain_end |=> (out_valid && out_last))
    else $error("last byte not presented after drain end");

endmodule

@@ design/header_length_frame_receiver.sv @@
// Header/length frame receiver.
// rx (sink): one received byte per request. The block hunts for '#', '@',
//   a length byte L and L payload bytes; frames with L of zero or with
//   3+L above the store depth are dropped, a stray second header byte drops
//   the frame, and '#' where '@' or the length is due restarts it.
// frame (source): on the final payload byte the whole stored frame
//   (header, length, payload: 3+L bytes) comes out one byte per request,
//   frame_last set on its final byte.
// Drain: the first frame byte is valid once the controller is in DRAIN and
//   the byte is loaded into the output register; the frame then drains at
//   one byte per cycle unless stalled, set by the store's single read port.
// Throughput: one input byte per cycle while hunting and collecting; rx
//   is held off while a frame drains, stalls included.
// Stalls: when frame.ready is low the output byte holds and the drain
//   pauses; once the last byte is in the output register rx is accepted
//   again.
// Reset (rst, synchronous): back to hunting for '#', no output pending.
//   The frame store is not cleared; only bytes of the current frame are read.
module header_length_frame_receiver (
  input logic   clk,
  input logic   rst,
  hlfr_in_if.sink    rx,
  hlfr_out_if.source frame
);
  import hlfr_pkg::*;

  cmd_t    cmd;
  status_t st;

  hlfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx.valid),
    .rx_ready (rx.ready),
    .st       (st),
    .cmd      (cmd)
  );

  hlfr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .rx_byte   (rx.rx_byte),
    .cmd       (cmd),
    .st        (st),
    .out_valid (frame.valid),
    .out_ready (frame.ready),
    .out_byte  (frame.frame_byte),
    .out_last  (frame.frame_last)
  );

endmodule
